// ===== src/srp_pkg.sv =====
package srp_pkg;

  localparam int SRP_MAX_BYTES = 8192;
  localparam int SRP_CNT_W     = $clog2(SRP_MAX_BYTES + 1);
  localparam int SRP_Q_DEPTH   = 4;
  localparam int SRP_Q_AW      = $clog2(SRP_Q_DEPTH);
  localparam int SRP_GROUP     = 5;

  localparam logic [7:0] SRP_SOX = 8'hF0;
  localparam logic [7:0] SRP_EOX = 8'hF7;

  localparam logic [7:0] SRP_HDR [SRP_GROUP] = '{8'hF0, 8'h00, 8'h20, 8'h0D, 8'h10};

  typedef enum logic [1:0] {
    KIND_REG = 2'd0,
    KIND_RAW = 2'd1,
    KIND_END = 2'd2
  } srp_kind_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_HDR   = 3'd1,
    ST_LEN   = 3'd2,
    ST_OVF   = 3'd3,
    ST_ABORT = 3'd4
  } srp_status_t;

  typedef struct packed {
    srp_kind_t   kind;
    logic [6:0]  subid;
    logic [31:0] word;
    srp_status_t status;
  } srp_entry_t;

endpackage

// ===== src/sysex_register_readback_parser_unit.sv =====
// SysEx register readback parser.
// Input: one MIDI byte per word on in_data_byte; taken when in_push is high and
// in_full is low. A byte can be taken every cycle.
// Output: queue-style; the oldest result sits on the out_ ports while out_empty
// is low and is taken when out_pop is high. Each byte yields zero or one result.
// kind 0 carries a register/value pair (sub-id 0), kind 1 a raw 32-bit word,
// kind 2 the end status with out_last set.
// Each result is written to the queue at the edge that takes its byte, then
// loaded from the queue into the output register, from which out_pop takes it.
// Throughput: one byte per cycle while in_full is low; a four-word queue plus
// the output register decouple the parser from the sink.
// When the sink stalls, the queue fills and in_full rises; bytes causing no
// result are still gated by in_full.
// Reset (synchronous, rst_n low): no message open, queue and output empty.
module sysex_register_readback_parser_unit
  import srp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [1:0]  out_kind,
  output logic [6:0]  out_subid,
  output logic [14:0] out_reg_number,
  output logic [15:0] out_reg_value,
  output logic [31:0] out_raw_word,
  output logic        out_parity_bad,
  output logic [2:0]  out_status,
  output logic        out_last
);

  logic       in_acc;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_avail;
  srp_entry_t f_ent;
  srp_entry_t q_ent;

  assign in_full = q_full;
  assign in_acc  = in_push && !q_full;

  srp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_acc),
    .byte_in  (in_data_byte),
    .ent_push (q_push),
    .ent      (f_ent)
  );

  srp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_ent (f_ent),
    .full   (q_full),
    .pop    (q_pop),
    .avail  (q_avail),
    .rd_ent (q_ent)
  );

  srp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_avail        (q_avail),
    .q_ent          (q_ent),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_kind       (out_kind),
    .out_subid      (out_subid),
    .out_reg_number (out_reg_number),
    .out_reg_value  (out_reg_value),
    .out_raw_word   (out_raw_word),
    .out_parity_bad (out_parity_bad),
    .out_status     (out_status),
    .out_last       (out_last)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("queue written while full");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_last == (out_kind == KIND_END)))
    else $error("last flag does not match end result");

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind != KIND_REG) |->
      (out_reg_number == 15'd0 && out_reg_value == 16'd0 && !out_parity_bad))
    else $error("register fields set on non-register result");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty) else $error("output not empty after reset");
`endif

endmodule

// ===== src/srp_front.sv =====
module srp_front
  import srp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_vld,
  input  logic [7:0] byte_in,
  output logic       ent_push,
  output srp_entry_t ent
);

  logic                 in_msg_r, in_msg_nxt;
  logic [SRP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 hdr_fail_r, hdr_fail_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [6:0]           subid_r, subid_nxt;
  logic [2:0]           grp_r, grp_nxt;
  logic [31:0]          acc_r, acc_nxt;
  logic [31:0]          part;
  logic [31:0]          word_w;

  always_comb begin
    case (grp_r)
      3'd0:    part = {25'd0, byte_in[6:0]};
      3'd1:    part = {18'd0, byte_in[6:0], 7'd0};
      3'd2:    part = {11'd0, byte_in[6:0], 14'd0};
      3'd3:    part = {4'd0, byte_in[6:0], 21'd0};
      3'd4:    part = {byte_in[3:0], 28'd0};
      default: part = 32'd0;
    endcase
  end

  assign word_w = acc_r | part;

  always_comb begin
    in_msg_nxt   = in_msg_r;
    cnt_nxt      = cnt_r;
    hdr_fail_nxt = hdr_fail_r;
    ovf_nxt      = ovf_r;
    subid_nxt    = subid_r;
    grp_nxt      = grp_r;
    acc_nxt      = acc_r;
    ent_push     = 1'b0;
    ent.kind     = KIND_END;
    ent.subid    = subid_r;
    ent.word     = 32'd0;
    ent.status   = ST_OK;
    if (byte_vld) begin
      if (byte_in == SRP_SOX) begin
        if (in_msg_r && !ovf_r) begin
          ent_push   = 1'b1;
          ent.status = ST_ABORT;
        end
        in_msg_nxt   = 1'b1;
        cnt_nxt      = SRP_CNT_W'(1);
        hdr_fail_nxt = 1'b0;
        ovf_nxt      = 1'b0;
        subid_nxt    = 7'd0;
        grp_nxt      = 3'd0;
        acc_nxt      = 32'd0;
      end else if (in_msg_r) begin
        if (ovf_r) begin
          if (byte_in == SRP_EOX) in_msg_nxt = 1'b0;
        end else if (cnt_r >= SRP_CNT_W'(SRP_MAX_BYTES)) begin
          ovf_nxt    = 1'b1;
          if (byte_in == SRP_EOX) in_msg_nxt = 1'b0;
          ent_push   = 1'b1;
          ent.status = ST_OVF;
        end else if (byte_in == SRP_EOX) begin
          in_msg_nxt = 1'b0;
          ent_push   = 1'b1;
          if (hdr_fail_r || cnt_r < SRP_CNT_W'(SRP_GROUP)) begin
            ent.status = ST_HDR;
          end else if (cnt_r < SRP_CNT_W'(SRP_GROUP + 1) || grp_r != 3'd0) begin
            ent.status = ST_LEN;
          end
        end else begin
          cnt_nxt = cnt_r + SRP_CNT_W'(1);
          if (cnt_r < SRP_CNT_W'(SRP_GROUP)) begin
            if (byte_in != SRP_HDR[cnt_r[2:0]]) hdr_fail_nxt = 1'b1;
          end else if (cnt_r == SRP_CNT_W'(SRP_GROUP)) begin
            subid_nxt = byte_in[6:0];
          end else if (grp_r == 3'(SRP_GROUP - 1)) begin
            grp_nxt = 3'd0;
            acc_nxt = 32'd0;
            if (!hdr_fail_r) begin
              ent_push = 1'b1;
              ent.kind = (subid_r == 7'd0) ? KIND_REG : KIND_RAW;
              ent.word = word_w;
            end
          end else begin
            grp_nxt = grp_r + 3'd1;
            acc_nxt = word_w;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r   <= 1'b0;
      cnt_r      <= '0;
      hdr_fail_r <= 1'b0;
      ovf_r      <= 1'b0;
      subid_r    <= 7'd0;
      grp_r      <= 3'd0;
      acc_r      <= 32'd0;
    end else begin
      in_msg_r   <= in_msg_nxt;
      cnt_r      <= cnt_nxt;
      hdr_fail_r <= hdr_fail_nxt;
      ovf_r      <= ovf_nxt;
      subid_r    <= subid_nxt;
      grp_r      <= grp_nxt;
      acc_r      <= acc_nxt;
    end
  end

endmodule

// ===== src/srp_queue.sv =====
module srp_queue
  import srp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  srp_entry_t wr_ent,
  output logic       full,
  input  logic       pop,
  output logic       avail,
  output srp_entry_t rd_ent
);

  srp_entry_t            mem [SRP_Q_DEPTH];
  logic [SRP_Q_AW-1:0]   wp_r, rp_r;
  logic [SRP_Q_AW:0]     cnt_r, cnt_nxt;

  assign full   = (cnt_r == (SRP_Q_AW+1)'(SRP_Q_DEPTH));
  assign avail  = (cnt_r != '0);
  assign rd_ent = mem[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wr_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== src/srp_back.sv =====
module srp_back
  import srp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_avail,
  input  srp_entry_t  q_ent,
  output logic        q_pop,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [1:0]  out_kind,
  output logic [6:0]  out_subid,
  output logic [14:0] out_reg_number,
  output logic [15:0] out_reg_value,
  output logic [31:0] out_raw_word,
  output logic        out_parity_bad,
  output logic [2:0]  out_status,
  output logic        out_last
);

  logic        vld_r;
  logic        is_reg;
  logic        is_end;

  assign is_reg = (q_ent.kind == KIND_REG);
  assign is_end = (q_ent.kind == KIND_END);
  assign q_pop  = q_avail && (!vld_r || out_pop);
  assign out_empty = !vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (q_pop) begin
      vld_r <= 1'b1;
    end else if (out_pop) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_kind       <= q_ent.kind;
      out_subid      <= q_ent.subid;
      out_reg_number <= is_reg ? q_ent.word[30:16] : 15'd0;
      out_reg_value  <= is_reg ? q_ent.word[15:0] : 16'd0;
      out_raw_word   <= q_ent.word;
      out_parity_bad <= is_reg && !(^q_ent.word);
      out_status     <= q_ent.status;
      out_last       <= is_end;
    end
  end

endmodule

// ===== tb/sysex_register_readback_parser_unit_test.sv =====
`timescale 1ns / 1ps

module sysex_register_readback_parser_unit_test;
  import srp_pkg::*;

  localparam logic [7:0] SOX = 8'hF0;
  localparam logic [7:0] EOX = 8'hF7;
  localparam logic [7:0] HDR [5] = '{8'hF0, 8'h00, 8'h20, 8'h0D, 8'h10};
  localparam int HOLD_FOR_DRAIN = -1;
  localparam int IDLE_LIMIT = 4000;
  localparam int FULL_WORDS = (SRP_MAX_BYTES - 6) / 5;

  typedef struct packed {
    srp_kind_t   kind;
    logic [6:0]  subid;
    logic [14:0] reg_number;
    logic [15:0] reg_value;
    logic [31:0] raw_word;
    logic        parity_bad;
    srp_status_t status;
    logic        last;
  } readback_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_pop = 1'b0;
  logic        out_empty;
  logic [1:0]  out_kind;
  logic [6:0]  out_subid;
  logic [14:0] out_reg_number;
  logic [15:0] out_reg_value;
  logic [31:0] out_raw_word;
  logic        out_parity_bad;
  logic [2:0]  out_status;
  logic        out_last;

  int        byte_stream[$];
  readback_t expected_words[$];
  int        fail_count = 0;

  // parser state mirror
  logic                 in_msg = 1'b0;
  logic [SRP_CNT_W-1:0] msg_bytes = '0;
  logic                 hdr_bad = 1'b0;
  logic                 ovf = 1'b0;
  logic [6:0]           held_subid = '0;
  logic [2:0]           grp = '0;
  logic [31:0]          acc = '0;

  sysex_register_readback_parser_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_data_byte   (in_data_byte),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_kind       (out_kind),
    .out_subid      (out_subid),
    .out_reg_number (out_reg_number),
    .out_reg_value  (out_reg_value),
    .out_raw_word   (out_raw_word),
    .out_parity_bad (out_parity_bad),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  always #6 clk = ~clk;

  task automatic parse_midi_byte(input logic [7:0] b);
    readback_t            r;
    logic [SRP_CNT_W-1:0] idx;
    logic [31:0]          w;
    r = '{kind: KIND_END, subid: held_subid, reg_number: '0, reg_value: '0,
          raw_word: '0, parity_bad: 1'b0, status: ST_OK, last: 1'b1};
    if (b == SOX) begin
      if (in_msg && !ovf) begin
        r.status = ST_ABORT;
        expected_words.push_back(r);
      end
      in_msg = 1'b1;
      msg_bytes = SRP_CNT_W'(1);
      hdr_bad = 1'b0;
      ovf = 1'b0;
      held_subid = '0;
      grp = '0;
      acc = '0;
    end else if (in_msg) begin
      if (ovf) begin
        if (b == EOX) in_msg = 1'b0;
      end else if (msg_bytes >= SRP_MAX_BYTES) begin
        ovf = 1'b1;
        if (b == EOX) in_msg = 1'b0;
        r.status = ST_OVF;
        expected_words.push_back(r);
      end else if (b == EOX) begin
        if (hdr_bad || msg_bytes < 5) r.status = ST_HDR;
        else if (msg_bytes < 6 || grp != 0) r.status = ST_LEN;
        else r.status = ST_OK;
        in_msg = 1'b0;
        expected_words.push_back(r);
      end else begin
        idx = msg_bytes;
        msg_bytes = msg_bytes + 1'b1;
        if (idx < 5) begin
          if (b != HDR[idx[2:0]]) hdr_bad = 1'b1;
        end else if (idx == 5) begin
          held_subid = b[6:0];
        end else begin
          acc = acc | (32'(b[6:0]) << (7 * grp));
          grp = grp + 1'b1;
          if (grp == 3'd5) begin
            w = acc;
            grp = '0;
            acc = '0;
            if (!hdr_bad) begin
              r.subid = held_subid;
              r.last = 1'b0;
              r.raw_word = w;
              if (held_subid == 7'd0) begin
                r.kind = KIND_REG;
                r.reg_number = w[30:16];
                r.reg_value = w[15:0];
                r.parity_bad = ~^w;
              end else begin
                r.kind = KIND_RAW;
              end
              expected_words.push_back(r);
            end
          end
        end
      end
    end
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == SOX || b == EOX) b[7] = 1'b0;
    return b;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    byte_stream.push_back(int'(b));
  endtask

  task automatic put_header(input logic [7:0] sid);
    for (int i = 0; i < 5; i++) put_byte(HDR[i]);
    put_byte(sid);
  endtask

  // 7-bit groups, little-endian; bit 7 and dropped top bits are random
  task automatic put_word(input logic [31:0] w);
    logic [34:0] ext;
    logic [7:0]  b;
    ext = {3'($urandom), w};
    for (int i = 0; i < 5; i++) begin
      b = {1'($urandom), ext[7*i +: 7]};
      if (b == SOX || b == EOX) b[7] = 1'b0;
      put_byte(b);
    end
  endtask

  task automatic put_random_words(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: put_word(32'h0000_0000);
        1: put_word(32'hFFFF_FFFF);
        default: put_word($urandom);
      endcase
    end
  endtask

  // driver
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) parse_midi_byte(in_data_byte);
      if (!in_push || !in_full) begin
        if (gap_left > 0) begin
          gap_left--;
          in_push <= 1'b0;
        end else if (byte_stream.size() == 0) begin
          in_push <= 1'b0;
        end else if (byte_stream[0] == HOLD_FOR_DRAIN) begin
          in_push <= 1'b0;
          if (expected_words.size() == 0) void'(byte_stream.pop_front());
        end else begin
          in_push <= 1'b1;
          in_data_byte <= 8'(byte_stream.pop_front());
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                     : $urandom_range(0, 20);
            gap_left = $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // monitor
  int        pop_mode = 0;
  int        mode_left = 0;
  logic [2:0] rx_tick = '0;
  readback_t got;
  readback_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        got = '{kind: srp_kind_t'(out_kind), subid: out_subid,
                reg_number: out_reg_number, reg_value: out_reg_value,
                raw_word: out_raw_word, parity_bad: out_parity_bad,
                status: srp_status_t'(out_status), last: out_last};
        if (expected_words.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected word: kind=%0d subid=%h word=%h status=%0d",
                     got.kind, got.subid, got.raw_word, got.status);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("mismatch at %0t:", $realtime);
              $display("  got  kind=%0d subid=%h reg=%h val=%h word=%h par=%b st=%0d last=%b",
                       got.kind, got.subid, got.reg_number, got.reg_value,
                       got.raw_word, got.parity_bad, got.status, got.last);
              $display("  want kind=%0d subid=%h reg=%h val=%h word=%h par=%b st=%0d last=%b",
                       want.kind, want.subid, want.reg_number, want.reg_value,
                       want.raw_word, want.parity_bad, want.status, want.last);
            end
            fail_count++;
          end
        end
      end
      if (mode_left == 0) begin
        pop_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      rx_tick <= rx_tick + 1'b1;
      case (pop_mode)
        0: out_pop <= 1'b1;
        1: out_pop <= 1'($urandom_range(0, 1));
        default: out_pop <= (rx_tick == 3'd0);
      endcase
    end
  end

  // watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("** sysex_register_readback_parser_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int base;
    int n;
    logic [7:0] sid;
    logic [7:0] hb [5];

    // stray bytes outside a message
    put_byte(8'h00); put_byte(EOX); put_byte(8'hFF); put_byte(8'h7F);
    // register pairs: all ones, all zeros, single bit
    put_header(8'h00);
    put_word(32'hFFFF_FFFF); put_word(32'h0000_0000); put_word(32'h0000_0001);
    put_byte(EOX);
    // raw words, sub-id with bit 7 set
    put_header(8'hFF);
    put_word(32'h8000_0000); put_word(32'h7FFF_FFFF);
    put_byte(EOX);
    // header mismatch, bit-7 header byte, early close
    put_byte(SOX); put_byte(8'h00); put_byte(8'h21); put_byte(8'h0D); put_byte(8'h10);
    put_byte(8'h00); put_word(32'h1234_5678); put_byte(EOX);
    put_byte(SOX); put_byte(8'h80); put_byte(EOX);
    put_byte(SOX); put_byte(EOX);
    // bad length: no sub-id, incomplete group
    put_byte(SOX); put_byte(8'h00); put_byte(8'h20); put_byte(8'h0D); put_byte(8'h10);
    put_byte(EOX);
    put_header(8'h03); put_word(32'hA5A5_5A5A); put_byte(8'h11); put_byte(EOX);
    // restart
    put_header(8'h00); put_byte(8'h01); put_byte(SOX);
    put_byte(8'h00); put_byte(EOX);
    byte_stream.push_back(HOLD_FOR_DRAIN);

    // exactly full length
    put_header(8'h00); put_random_words(FULL_WORDS); put_byte(EOX);
    // overflow on the closing byte, then a stray byte
    put_header(8'h05); put_random_words(FULL_WORDS); put_byte(8'h22); put_byte(EOX);
    put_byte(8'h42);
    // overflow on data, discarded bytes, quiet close
    put_header(8'h00); put_random_words(FULL_WORDS); put_byte(8'h01); put_byte(8'h02);
    put_byte(8'h33); put_byte(8'hFE); put_byte(EOX); put_byte(8'h55);
    // overflow on data, then a silent restart
    put_header(8'h09); put_random_words(FULL_WORDS); put_byte(8'h01); put_byte(8'h02);
    put_byte(8'h44); put_byte(SOX);
    put_byte(8'h00); put_byte(8'h20); put_byte(8'h0D); put_byte(8'h10); put_byte(8'h00);
    put_word(32'hDEAD_BEEF); put_byte(EOX);
    byte_stream.push_back(HOLD_FOR_DRAIN);

    base = byte_stream.size();
    while (byte_stream.size() - base < 700) begin
      case ($urandom_range(0, 1))
        0: sid = 8'($urandom_range(0, 1) << 7);
        default: sid = plain_byte();
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          put_header(sid); put_random_words($urandom_range(0, 4)); put_byte(EOX);
        end
        5: begin
          put_header(sid); put_random_words($urandom_range(0, 2));
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) put_byte(plain_byte());
          put_byte(EOX);
        end
        6: begin
          hb = HDR;
          hb[$urandom_range(1, 4)] = plain_byte();
          for (int i = 0; i < 5; i++) put_byte(hb[i]);
          put_byte(sid); put_random_words($urandom_range(0, 3));
          if ($urandom_range(0, 3) != 0) put_byte(EOX);
        end
        7: begin
          n = $urandom_range(0, 5);
          for (int i = 0; i < n; i++) put_byte(HDR[i]);
          if (n == 5) put_byte(EOX);
          else put_byte(($urandom_range(0, 1) == 0) ? EOX : SOX);
        end
        8: begin
          put_header(sid); put_random_words($urandom_range(0, 2));
          n = $urandom_range(0, 3);
          for (int i = 0; i < n; i++) put_byte(plain_byte());
        end
        default: begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) put_byte(8'($urandom));
          if ($urandom_range(0, 3) == 0) byte_stream.push_back(HOLD_FOR_DRAIN);
        end
      endcase
    end
    put_byte(EOX);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_stream.size() != 0 || in_push || expected_words.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("** sysex_register_readback_parser_unit: PASSED **");
    end else begin
      $display("** sysex_register_readback_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule
